### sv/assert_macros.svh
// Assertion macros shared by the cache tag store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, switched off while reset is high.
`define SALP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication checked at every rising clock edge, switched off while reset is high.
`define SALP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

### sv/salp_pkg.sv
// Package with the types and constants of the cache tag store.
package salp_pkg;

   localparam int MAX_SETS = 256;
   localparam int MAX_WAYS = 8;
   localparam int SET_W    = $clog2(MAX_SETS);
   localparam int WAY_W    = 3;
   localparam int LINES    = MAX_SETS * MAX_WAYS;
   localparam int LINE_AW  = $clog2(LINES);

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_SET_BITS   = 2'd0;
   localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS       = 2'd2;
   localparam logic [1:0] REG_LRU_MODE   = 2'd3;

   // Access kinds.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way_used;
      logic             write_back;
      logic [31:0]      victim_block_address;
   } rsp_type;

   // One way of one set as held in the line memory.
   typedef struct packed {
      logic        valid;
      logic        dirty;
      logic [31:0] tag;
      logic [31:0] blk;
      logic [31:0] age;
      logic [31:0] use_count;
   } line_type;

   // What the way unit reports for the way under evaluation.
   typedef struct packed {
      line_type aged;
      logic     match;
      logic     invalid;
      logic     take;
   } eval_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_FINAL
   } state_type;

endpackage

### sv/salp_way_unit.sv
// Shared way unit: ages one way, compares its tag and ranks it as a victim.
module salp_way_unit (
   input  salp_pkg::line_type line_i,
   input  logic [31:0]        tag_i,
   input  logic               first_i,
   input  logic               lru_mode_i,
   input  logic [31:0]        best_age_i,
   input  logic [31:0]        best_use_i,
   output salp_pkg::eval_type eval_o
);
   import salp_pkg::*;

   logic [31:0] aged_age;

   // Valid ways age by one, saturating.
   always_comb begin
      aged_age = line_i.age;
      if (line_i.valid && (line_i.age != '1)) begin
         aged_age = line_i.age + 32'd1;
      end
   end

   // Tag compare, free way detection and victim ranking against the best so far.
   always_comb begin
      eval_o          = '0;
      eval_o.aged     = line_i;
      eval_o.aged.age = aged_age;
      eval_o.match    = line_i.valid && (line_i.tag == tag_i);
      eval_o.invalid  = !line_i.valid;
      if (first_i) begin
         eval_o.take = 1'b1;
      end else if (lru_mode_i) begin
         eval_o.take = best_age_i < aged_age;
      end else if (best_use_i == line_i.use_count) begin
         eval_o.take = best_age_i < aged_age;
      end else begin
         eval_o.take = best_use_i > line_i.use_count;
      end
   end

endmodule

### sv/set_assoc_cache_lru_lfu_policy.sv
// Top level of the set-associative write-back cache tag store.
// One access is taken when start is high and busy is low. The ways of the
// addressed set are read one at a time from the line memory through the
// shared way unit, each written back aged, and then the chosen way is written;
// busy stays high from acceptance until that final write, with ways_in_use
// taken as 1 to 8. The result word appears on rsp_data for exactly
// one cycle with rsp_valid high, in the first cycle in which busy is low again,
// and cannot be held off. After reset a clearing pass walks all 2048 lines of the
// line memory while busy stays high; configuration writes are taken throughout.
module set_assoc_cache_lru_lfu_policy (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  salp_pkg::req_type req_data,
   output logic              rsp_valid,
   output salp_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import salp_pkg::*;

   `include "assert_macros.svh"

   // Configuration registers.
   logic [3:0] set_bits_ff, block_bits_ff, ways_ff;
   logic       lru_mode_ff;
   logic       cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 4'd0;
         block_bits_ff <= 4'd2;
         ways_ff       <= 4'd1;
         lru_mode_ff   <= 1'b0;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_SET_BITS:   set_bits_ff   <= pwdata[3:0];
            REG_BLOCK_BITS: block_bits_ff <= pwdata[3:0];
            REG_WAYS:       ways_ff       <= pwdata[3:0];
            REG_LRU_MODE:   lru_mode_ff   <= pwdata[0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SET_BITS:   prdata = {28'd0, set_bits_ff};
         REG_BLOCK_BITS: prdata = {28'd0, block_bits_ff};
         REG_WAYS:       prdata = {28'd0, ways_ff};
         REG_LRU_MODE:   prdata = {31'd0, lru_mode_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // Address decode of the incoming word.
   logic [31:0]      set_full, tag_calc, blk_calc;
   logic [4:0]       shift_tag;
   logic [3:0]       nways;
   logic [WAY_W-1:0] last_way;

   always_comb begin
      set_full  = (req_data.address >> block_bits_ff) & ((32'd1 << set_bits_ff) - 32'd1);
      shift_tag = {1'b0, set_bits_ff} + {1'b0, block_bits_ff};
      tag_calc  = req_data.address >> shift_tag;
      blk_calc  = req_data.address & ~((32'd1 << block_bits_ff) - 32'd1);
      if (ways_ff == 4'd0) begin
         nways = 4'd1;
      end else if (ways_ff > 4'(MAX_WAYS)) begin
         nways = 4'(MAX_WAYS);
      end else begin
         nways = ways_ff;
      end
      last_way = WAY_W'(nways - 4'd1);
   end

   // Sequencer and working registers.
   state_type        state_ff, state_in;
   logic [LINE_AW-1:0] clr_ff, clr_in;
   logic [WAY_W-1:0] way_ff, way_in, last_ff, last_in;
   logic             wr_ff, wr_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [31:0]      tag_ff, tag_in, blk_ff, blk_in;
   logic             hit_ff, hit_in, inv_ff, inv_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in, inv_way_ff, inv_way_in;
   line_type         hit_line_ff, hit_line_in;
   logic [WAY_W-1:0] vic_way_ff, vic_way_in;
   logic [31:0]      vic_age_ff, vic_age_in, vic_use_ff, vic_use_in;
   logic             vic_dirty_ff, vic_dirty_in;
   logic [31:0]      vic_blk_ff, vic_blk_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // Line memory: one write and one registered read a cycle.
   line_type           line_mem [LINES];
   line_type           mem_rdata_ff;
   logic               mem_we;
   logic [LINE_AW-1:0] mem_waddr, mem_raddr;
   line_type           mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= line_mem[mem_raddr];
   end

   eval_type eval;

   salp_way_unit u_way (
      .line_i     (mem_rdata_ff),
      .tag_i      (tag_ff),
      .first_i    (way_ff == '0),
      .lru_mode_i (lru_mode_ff),
      .best_age_i (vic_age_ff),
      .best_use_i (vic_use_ff),
      .eval_o     (eval)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      way_ff       <= way_in;
      last_ff      <= last_in;
      wr_ff        <= wr_in;
      set_ff       <= set_in;
      tag_ff       <= tag_in;
      blk_ff       <= blk_in;
      hit_ff       <= hit_in;
      inv_ff       <= inv_in;
      hit_way_ff   <= hit_way_in;
      inv_way_ff   <= inv_way_in;
      hit_line_ff  <= hit_line_in;
      vic_way_ff   <= vic_way_in;
      vic_age_ff   <= vic_age_in;
      vic_use_ff   <= vic_use_in;
      vic_dirty_ff <= vic_dirty_in;
      vic_blk_ff   <= vic_blk_in;
      rsp_ff       <= rsp_in;
   end

   // Next state, memory control and result formation.
   always_comb begin
      logic [WAY_W-1:0] pick;
      state_in     = state_ff;
      clr_in       = clr_ff;
      way_in       = way_ff;
      last_in      = last_ff;
      wr_in        = wr_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      blk_in       = blk_ff;
      hit_in       = hit_ff;
      inv_in       = inv_ff;
      hit_way_in   = hit_way_ff;
      inv_way_in   = inv_way_ff;
      hit_line_in  = hit_line_ff;
      vic_way_in   = vic_way_ff;
      vic_age_in   = vic_age_ff;
      vic_use_in   = vic_use_ff;
      vic_dirty_in = vic_dirty_ff;
      vic_blk_in   = vic_blk_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = {set_ff, way_ff};
      mem_raddr    = {set_ff, way_ff};
      mem_wdata    = eval.aged;
      pick         = way_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               wr_in    = (req_data.opcode == OP_WRITE);
               set_in   = set_full[SET_W-1:0];
               tag_in   = tag_calc;
               blk_in   = blk_calc;
               last_in  = last_way;
               way_in   = '0;
               hit_in   = 1'b0;
               inv_in   = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            // Write back the aged way and note hit, free way and victim.
            mem_we = 1'b1;
            if (eval.match && !hit_ff) begin
               hit_in      = 1'b1;
               hit_way_in  = way_ff;
               hit_line_in = eval.aged;
            end
            if (eval.invalid && !inv_ff) begin
               inv_in     = 1'b1;
               inv_way_in = way_ff;
            end
            if (eval.take) begin
               vic_way_in   = way_ff;
               vic_age_in   = eval.aged.age;
               vic_use_in   = eval.aged.use_count;
               vic_dirty_in = eval.aged.dirty;
               vic_blk_in   = eval.aged.blk;
            end
            if (way_ff == last_ff) begin
               state_in = S_FINAL;
            end else begin
               way_in   = way_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_FINAL: begin
            // Update the hit way or fill the free or victim way.
            mem_we = 1'b1;
            if (hit_ff) begin
               pick                = hit_way_ff;
               mem_wdata           = hit_line_ff;
               mem_wdata.dirty     = hit_line_ff.dirty | wr_ff;
               mem_wdata.age       = '0;
               if (hit_line_ff.use_count != '1) begin
                  mem_wdata.use_count = hit_line_ff.use_count + 32'd1;
               end
            end else begin
               pick                = inv_ff ? inv_way_ff : vic_way_ff;
               mem_wdata.valid     = 1'b1;
               mem_wdata.dirty     = wr_ff;
               mem_wdata.tag       = tag_ff;
               mem_wdata.blk       = blk_ff;
               mem_wdata.age       = '0;
               mem_wdata.use_count = 32'd1;
            end
            mem_waddr                   = {set_ff, pick};
            rsp_valid_in                = 1'b1;
            rsp_in.hit                  = hit_ff;
            rsp_in.way_used             = pick;
            rsp_in.write_back           = !hit_ff && !inv_ff && vic_dirty_ff;
            rsp_in.victim_block_address = (!hit_ff && !inv_ff && vic_dirty_ff) ?
                                          vic_blk_ff : 32'd0;
            state_in                    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result word only follows the final write of an access.
   `SALP_ASSERT_IMP(a_rsp_after_final, rsp_valid, $past(state_ff) == S_FINAL, "stray result word")
   // An accepted access keeps the block busy in the next cycle.
   `SALP_ASSERT_IMP(a_busy_after_start, start && !busy, ##1 busy, "access not started")
   // No victim address without a write-back.
   `SALP_ASSERT_IMP(a_victim_zero, rsp_valid && !rsp_data.write_back,
                    rsp_data.victim_block_address == 32'd0, "victim address without write-back")

endmodule
